/* design/gpc_pkg.sv */
// shared types, codes and constant tables of the gear predictor-corrector
package gpc_pkg;

    localparam int LANES      = 6;
    localparam int STEP_BITS  = 47;
    localparam int FIELD_BITS = 48;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_CORRECT = 1'b1;

    localparam logic CFG_HALF_STEP_SQ = 1'b0;
    localparam logic CFG_INV_STEP     = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_PMUL,
        ST_PADD,
        ST_INC,
        ST_CSCALE,
        ST_DELTA,
        ST_GAIN,
        ST_CADD,
        ST_VEL,
        ST_STORE,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MULK
    } t_alu_op;

    localparam logic [3:0] PASCAL [LANES][LANES] = '{
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5},
        '{4'd0, 4'd0, 4'd1, 4'd3, 4'd6, 4'd10},
        '{4'd0, 4'd0, 4'd0, 4'd1, 4'd4, 4'd10},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd5},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1}
    };

    // lane two uses delta itself
    localparam logic [31:0] GAIN [LANES] = '{
        32'd805306368, 32'd2994546642, 32'd0,
        32'd2624702236, 32'd715827883, 32'd71582788
    };

endpackage

/* design/gpc_alu.sv */
// saturating add, subtract and small-integer multiply unit
module gpc_alu #(
    parameter int VALUE_BITS = 48
) (
    input  gpc_pkg::t_alu_op               i_op,
    input  logic signed [VALUE_BITS-1:0]   i_a,
    input  logic signed [VALUE_BITS-1:0]   i_b,
    input  logic [3:0]                     i_k,
    output logic signed [VALUE_BITS-1:0]   o_y,
    output logic                           o_sat
);
    import gpc_pkg::*;

    localparam int PW = VALUE_BITS + 5;
    localparam logic signed [VALUE_BITS:0] SUM_HI = {2'b00, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS:0] SUM_LO = {2'b11, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [PW-1:0] PRD_HI = {6'b000000, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [PW-1:0] PRD_LO = {6'b111111, {(VALUE_BITS-1){1'b0}}};

    logic signed [VALUE_BITS:0] sum;
    logic signed [PW-1:0]       prod;

    always_comb begin
        sum  = '0;
        prod = '0;
        o_y   = '0;
        o_sat = 1'b0;
        unique case (i_op)
            ALU_ADD, ALU_SUB: begin
                if (i_op == ALU_ADD) begin
                    sum = (VALUE_BITS+1)'(i_a) + (VALUE_BITS+1)'(i_b);
                end else begin
                    sum = (VALUE_BITS+1)'(i_a) - (VALUE_BITS+1)'(i_b);
                end
                if (sum > SUM_HI) begin
                    o_y   = SUM_HI[VALUE_BITS-1:0];
                    o_sat = 1'b1;
                end else if (sum < SUM_LO) begin
                    o_y   = SUM_LO[VALUE_BITS-1:0];
                    o_sat = 1'b1;
                end else begin
                    o_y = sum[VALUE_BITS-1:0];
                end
            end
            ALU_MULK: begin
                prod = PW'(i_a) * PW'(signed'({1'b0, i_k}));
                if (prod > PRD_HI) begin
                    o_y   = PRD_HI[VALUE_BITS-1:0];
                    o_sat = 1'b1;
                end else if (prod < PRD_LO) begin
                    o_y   = PRD_LO[VALUE_BITS-1:0];
                    o_sat = 1'b1;
                end else begin
                    o_y = prod[VALUE_BITS-1:0];
                end
            end
            default: begin
                o_y   = '0;
                o_sat = 1'b0;
            end
        endcase
    end

endmodule

/* design/gpc_mulq.sv */
// multi-cycle fixed-point multiplier: 32x32 partial products, round, clamp
module gpc_mulq #(
    parameter int VALUE_BITS = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [VALUE_BITS-1:0]   i_a,
    input  logic [gpc_pkg::STEP_BITS-1:0]  i_b,
    output logic                           o_done,
    output logic signed [VALUE_BITS-1:0]   o_y,
    output logic                           o_sat
);
    import gpc_pkg::*;

    localparam int PW = VALUE_BITS + STEP_BITS;
    localparam int RW = PW - 31;
    localparam logic [RW-1:0] VMAX = {{(RW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] YMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] YMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [63:0]     r_m;
    logic [63:0]     r_b;
    logic            r_neg;
    logic [PW-1:0]   r_acc;
    logic [2:0]      r_p;
    logic            r_busy;
    logic            r_done;
    logic [VALUE_BITS-1:0] r_y;
    logic            r_sat;

    logic [VALUE_BITS-1:0] mag;
    logic [63:0]     pp;
    logic [6:0]      shift;
    logic [127:0]    term;
    logic [PW:0]     rsum;
    logic [RW-1:0]   rr;

    always_comb begin
        mag   = i_a[VALUE_BITS-1] ? VALUE_BITS'(-i_a) : VALUE_BITS'(i_a);
        pp    = 64'(r_m[32*r_p[1] +: 32]) * 64'(r_b[32*r_p[0] +: 32]);
        shift = 7'(32 * (32'(r_p[1]) + 32'(r_p[0])));
        term  = 128'(pp) << shift;
        rsum  = (PW+1)'(r_acc) + (PW+1)'(33'h080000000);
        rr    = rsum[PW:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_p    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_m    <= 64'(mag);
                r_b    <= 64'(i_b);
                r_neg  <= i_a[VALUE_BITS-1];
                r_acc  <= '0;
                r_p    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_p != 3'd4) begin
                    r_acc <= r_acc + PW'(term);
                    r_p   <= r_p + 3'd1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (rr > VMAX + RW'(r_neg)) begin
                        r_sat <= 1'b1;
                        r_y   <= r_neg ? YMIN : YMAX;
                    end else begin
                        r_sat <= 1'b0;
                        r_y   <= r_neg ? VALUE_BITS'(-rr) : VALUE_BITS'(rr);
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;
    assign o_sat  = r_sat;

endmodule

/* design/gear_predictor_corrector.sv */
// sixth-order gear predictor-corrector over a bank of nordsieck vectors
// After reset the block clears both vector memories, one word of each per cycle for all
// ENTRIES*6 words, and stalls its input meanwhile. One request is worked at a time: the
// vectors are fetched, the shared saturating unit then forms the pascal products and sums
// plus, on a predict, the increment, and each fractional multiply runs on the 32x32
// multiplier (one on predict, two plus five gains on correct, the unit gain lane skipping
// the multiplier); the six lanes are then written back and the result handed over. The
// input reopens in the cycle the result appears, and an out-of-range entry index skips
// to the hand-over and answers with all fields zero.
module gear_predictor_corrector #(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 48
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [gpc_pkg::STEP_BITS-1:0]    i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [5:0]                       i_entry_index,
    input  logic                             i_load_position,
    input  logic signed [gpc_pkg::FIELD_BITS-1:0] i_position_in,
    input  logic signed [gpc_pkg::FIELD_BITS-1:0] i_acceleration,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [gpc_pkg::FIELD_BITS-1:0] o_position_out,
    output logic signed [gpc_pkg::FIELD_BITS-1:0] o_velocity_out,
    output logic signed [gpc_pkg::FIELD_BITS-1:0] o_step_increment,
    output logic                             o_saturated
);
    import gpc_pkg::*;

    localparam int DEPTH = ENTRIES * LANES;
    localparam int AW    = $clog2(DEPTH);
    localparam int VB    = VALUE_BITS;
    localparam logic signed [64:0] IN_HI  = {{(66-VB){1'b0}}, {(VB-1){1'b1}}};
    localparam logic signed [64:0] IN_LO  = {{(66-VB){1'b1}}, {(VB-1){1'b0}}};
    localparam logic signed [64:0] OUT_HI = {18'h00000, {47{1'b1}}};
    localparam logic signed [64:0] OUT_LO = {18'h3ffff, {47{1'b0}}};

    t_state r_state, n_state;

    logic [VB-1:0] r_corr_mem [DEPTH];
    logic [VB-1:0] r_pred_mem [DEPTH];
    logic [VB-1:0] r_corr_rd;
    logic [VB-1:0] r_pred_rd;

    logic [STEP_BITS-1:0] r_hss;
    logic [STEP_BITS-1:0] r_inv;

    logic signed [VB-1:0] r_cv [LANES];
    logic signed [VB-1:0] r_pv [LANES];
    logic signed [VB-1:0] r_acc;
    logic signed [VB-1:0] r_t;
    logic signed [VB-1:0] r_delta;
    logic signed [VB-1:0] r_inc;
    logic signed [VB-1:0] r_vel;

    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_base;
    logic [2:0]    r_cnt;
    logic [2:0]    r_i;
    logic [2:0]    r_j;
    logic          r_mode;
    logic          r_load;
    logic          r_zero;
    logic          r_sat;
    logic          r_go;
    logic signed [FIELD_BITS-1:0] r_pos_in;
    logic signed [FIELD_BITS-1:0] r_accel;

    logic                      r_out_valid;
    logic signed [FIELD_BITS-1:0] r_pos_out;
    logic signed [FIELD_BITS-1:0] r_vel_out;
    logic signed [FIELD_BITS-1:0] r_inc_out;
    logic                      r_sat_out;

    logic          accept;
    logic          out_free;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [VB-1:0] mem_wc;
    logic [VB-1:0] mem_wp;

    t_alu_op              alu_op;
    logic signed [VB-1:0] alu_a;
    logic signed [VB-1:0] alu_b;
    logic [3:0]           alu_k;
    logic signed [VB-1:0] alu_y;
    logic                 alu_sat;

    logic                 mul_start;
    logic                 mul_done;
    logic signed [VB-1:0] mul_a;
    logic [STEP_BITS-1:0] mul_b;
    logic signed [VB-1:0] mul_y;
    logic                 mul_sat;
    logic                 mul_state;

    logic signed [64:0]   pos_w;
    logic signed [64:0]   acc_w;
    logic signed [VB-1:0] pos_c;
    logic signed [VB-1:0] acc_c;
    logic                 pos_sat;
    logic                 acc_sat;

    logic signed [64:0]   o_src [3];
    logic signed [FIELD_BITS-1:0] o_cl [3];
    logic [2:0]           o_sat;

    gpc_alu #(.VALUE_BITS(VB)) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_k   (alu_k),
        .o_y   (alu_y),
        .o_sat (alu_sat)
    );

    gpc_mulq #(.VALUE_BITS(VB)) u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_y     (mul_y),
        .o_sat   (mul_sat)
    );

    // input and output range clamps
    always_comb begin
        pos_w   = 65'(r_pos_in);
        acc_w   = 65'(r_accel);
        pos_sat = (pos_w > IN_HI) || (pos_w < IN_LO);
        acc_sat = (acc_w > IN_HI) || (acc_w < IN_LO);
        pos_c   = (pos_w > IN_HI) ? IN_HI[VB-1:0] :
                  (pos_w < IN_LO) ? IN_LO[VB-1:0] : pos_w[VB-1:0];
        acc_c   = (acc_w > IN_HI) ? IN_HI[VB-1:0] :
                  (acc_w < IN_LO) ? IN_LO[VB-1:0] : acc_w[VB-1:0];

        o_src[0] = 65'(r_mode == MODE_CORRECT ? r_cv[0] : r_pv[0]);
        o_src[1] = 65'(r_vel);
        o_src[2] = 65'(r_inc);
        for (int k = 0; k < 3; k++) begin
            o_sat[k] = (o_src[k] > OUT_HI) || (o_src[k] < OUT_LO);
            o_cl[k]  = (o_src[k] > OUT_HI) ? OUT_HI[FIELD_BITS-1:0] :
                       (o_src[k] < OUT_LO) ? OUT_LO[FIELD_BITS-1:0] :
                       o_src[k][FIELD_BITS-1:0];
        end
    end

    // shared unit operand selection
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        alu_k  = '0;
        mul_a  = r_acc;
        mul_b  = r_hss;
        unique case (r_state)
            ST_PMUL: begin
                alu_op = ALU_MULK;
                alu_a  = r_cv[r_j];
                alu_k  = PASCAL[r_i][r_j];
            end
            ST_PADD: begin
                alu_a = r_acc;
                alu_b = r_t;
            end
            ST_INC: begin
                alu_a = r_acc;
                alu_b = r_cv[r_j];
            end
            ST_DELTA: begin
                alu_op = ALU_SUB;
                alu_a  = r_t;
                alu_b  = r_pv[2];
            end
            ST_CADD: begin
                alu_a = r_pv[r_i];
                alu_b = r_t;
            end
            ST_GAIN: begin
                mul_a = r_delta;
                mul_b = STEP_BITS'(GAIN[r_i]);
            end
            ST_VEL: begin
                mul_a = (r_mode == MODE_CORRECT) ? r_cv[1] : r_pv[1];
                mul_b = r_inv;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    assign mul_state = (r_state == ST_CSCALE) || (r_state == ST_VEL) ||
                       ((r_state == ST_GAIN) && (r_i != 3'd2));
    assign mul_start = mul_state && !r_go;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = (32'(i_entry_index) >= ENTRIES) ? ST_FINISH : ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (r_cnt == 3'd6) begin
                    n_state = (r_mode == MODE_CORRECT) ? ST_CSCALE : ST_PMUL;
                end
            end
            ST_PMUL: n_state = ST_PADD;
            ST_PADD: begin
                if (r_j == 3'd5 && r_i == 3'd5) begin
                    n_state = ST_INC;
                end else begin
                    n_state = ST_PMUL;
                end
            end
            ST_INC: begin
                if (r_j == 3'd5) begin
                    n_state = ST_VEL;
                end
            end
            ST_CSCALE: begin
                if (mul_done) begin
                    n_state = ST_DELTA;
                end
            end
            ST_DELTA: n_state = ST_GAIN;
            ST_GAIN: begin
                if (r_i == 3'd2 || mul_done) begin
                    n_state = ST_CADD;
                end
            end
            ST_CADD: n_state = (r_i == 3'd5) ? ST_VEL : ST_GAIN;
            ST_VEL: begin
                if (mul_done) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (r_cnt == 3'd5) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // vector memories
    always_comb begin
        mem_we = (r_state == ST_CLEAR) || (r_state == ST_STORE);
        mem_wa = (r_state == ST_CLEAR) ? r_clr : r_base + AW'(r_cnt);
        mem_wc = (r_state == ST_CLEAR) ? '0 : r_cv[r_cnt];
        mem_wp = (r_state == ST_CLEAR) ? '0 : r_pv[r_cnt];
        mem_ra = r_base + AW'(r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_corr_mem[mem_wa] <= mem_wc;
            r_pred_mem[mem_wa] <= mem_wp;
        end
        r_corr_rd <= r_corr_mem[mem_ra];
        r_pred_rd <= r_pred_mem[mem_ra];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hss <= '0;
            r_inv <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_STEP_SQ: r_hss <= i_cfg_data;
                CFG_INV_STEP:     r_inv <= i_cfg_data;
                default:          r_hss <= r_hss;
            endcase
        end
    end

    // datapath and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_cnt <= '0;
            r_i   <= '0;
            r_j   <= '0;
            r_go  <= 1'b0;
            r_sat <= 1'b0;
        end else begin
            if (mul_start) begin
                r_go <= 1'b1;
            end
            if (mul_done) begin
                r_go  <= 1'b0;
                r_sat <= r_sat | mul_sat;
            end
            unique case (r_state)
                ST_CLEAR: r_clr <= r_clr + AW'(1);
                ST_IDLE: begin
                    if (accept) begin
                        r_mode   <= i_mode;
                        r_load   <= i_load_position;
                        r_pos_in <= i_position_in;
                        r_accel  <= i_acceleration;
                        r_base   <= AW'(32'(i_entry_index) * LANES);
                        r_zero   <= (32'(i_entry_index) >= ENTRIES);
                        r_cnt    <= '0;
                        r_sat    <= 1'b0;
                    end
                end
                ST_FETCH: begin
                    if (r_cnt != 3'd0) begin
                        r_cv[r_cnt - 3'd1] <= r_corr_rd;
                        r_pv[r_cnt - 3'd1] <= r_pred_rd;
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd6) begin
                        r_i <= '0;
                        r_j <= '0;
                        if (r_mode == MODE_CORRECT) begin
                            r_acc <= acc_c;
                            r_sat <= acc_sat;
                        end else begin
                            r_acc <= '0;
                            if (r_load) begin
                                r_cv[0] <= pos_c;
                                r_sat   <= pos_sat;
                            end
                        end
                    end
                end
                ST_PMUL: begin
                    r_t   <= alu_y;
                    r_sat <= r_sat | alu_sat;
                end
                ST_PADD: begin
                    r_sat <= r_sat | alu_sat;
                    if (r_j == 3'd5) begin
                        r_pv[r_i] <= alu_y;
                        r_acc     <= '0;
                        r_i       <= r_i + 3'd1;
                        r_j       <= (r_i == 3'd5) ? 3'd1 : r_i + 3'd1;
                    end else begin
                        r_acc <= alu_y;
                        r_j   <= r_j + 3'd1;
                    end
                end
                ST_INC: begin
                    r_sat <= r_sat | alu_sat;
                    r_acc <= alu_y;
                    r_j   <= r_j + 3'd1;
                    if (r_j == 3'd5) begin
                        r_inc <= alu_y;
                    end
                end
                ST_CSCALE: begin
                    if (mul_done) begin
                        r_t <= mul_y;
                    end
                end
                ST_DELTA: begin
                    r_delta <= alu_y;
                    r_sat   <= r_sat | alu_sat;
                    r_i     <= '0;
                end
                ST_GAIN: begin
                    if (r_i == 3'd2) begin
                        r_t <= r_delta;
                    end else if (mul_done) begin
                        r_t <= mul_y;
                    end
                end
                ST_CADD: begin
                    r_cv[r_i] <= alu_y;
                    r_sat     <= r_sat | alu_sat;
                    r_i       <= r_i + 3'd1;
                    if (r_i == 3'd0) begin
                        r_inc <= r_t;
                    end
                end
                ST_VEL: begin
                    if (mul_done) begin
                        r_vel <= mul_y;
                        r_cnt <= '0;
                    end
                end
                ST_STORE: r_cnt <= r_cnt + 3'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
                if (r_zero) begin
                    r_pos_out <= '0;
                    r_vel_out <= '0;
                    r_inc_out <= '0;
                    r_sat_out <= 1'b0;
                end else begin
                    r_pos_out <= o_cl[0];
                    r_vel_out <= o_cl[1];
                    r_inc_out <= o_cl[2];
                    r_sat_out <= r_sat | (|o_sat);
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position_out   = r_pos_out;
    assign o_velocity_out   = r_vel_out;
    assign o_step_increment = r_inc_out;
    assign o_saturated      = r_sat_out;

endmodule

/* design/gpc_checker.sv */
// port-level checks of the gear predictor-corrector and their binding
module gpc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while a request is in work");

    // memory clearing keeps the input stalled
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open right after reset");

    // a result only appears from a busy block
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

endmodule

bind gear_predictor_corrector gpc_checker u_gpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
